[design/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion, suspended while reset is active
`define OGMP_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ogmp assertion failed");

// Concurrent assertion that is also checked during reset
`define OGMP_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("ogmp reset assertion failed");

`endif

[design/ogmp_pkg.sv]
// Shared types, constants and helpers of the occupancy grid max pool unit
package ogmp_pkg;

  localparam int DEF_MAX_WIDTH  = 4096;
  localparam int DEF_MAX_FACTOR = 16;
  localparam int MAX_HEIGHT     = 4096;
  localparam int QUEUE_DEPTH    = 4;

  localparam int CELL_W       = 8;
  localparam int FACTOR_W     = 5;
  localparam int GRID_W       = 13;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_POOL_FACTOR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_GRID_HEIGHT = 2'd2;

  localparam logic [FACTOR_W-1:0] RST_POOL_FACTOR = 5'd2;
  localparam logic [GRID_W-1:0]   RST_GRID_WIDTH  = 13'd4096;
  localparam logic [GRID_W-1:0]   RST_GRID_HEIGHT = 13'd4096;

  localparam logic signed [CELL_W-1:0] UNKNOWN_CELL = -8'sd1;

  // Where the accumulator of a cell comes from
  typedef enum logic [1:0] {
    SRC_INIT = 2'd0,  // first cell of a block
    SRC_PREV = 2'd1,  // previous cell's running maximum
    SRC_MEM  = 2'd2,  // line buffer entry of the block column
    SRC_PASS = 2'd3   // factor 1, no pooling
  } src_sel_t;

  typedef struct packed {
    logic [FACTOR_W-1:0] pool_factor;
    logic [GRID_W-1:0]   grid_width;
    logic [GRID_W-1:0]   grid_height;
  } cfg_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Address width for a given depth, at least one bit
  function automatic int addr_width(input int depth);
    return max_int(1, $clog2(depth));
  endfunction

endpackage

[design/ogmp_if.sv]
// Channel interfaces: cell input, pooled result output and register writes
interface ogmp_in_if;
  import ogmp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] cell_value;
  modport source (output valid, output cell_value, input ready);
  modport sink (input valid, input cell_value, output ready);
endinterface

interface ogmp_out_if;
  import ogmp_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [CELL_W-1:0] pooled_value;
  logic                     frame_end;
  modport source (output valid, output pooled_value, output frame_end, input ready);
  modport sink (input valid, input pooled_value, input frame_end, output ready);
endinterface

interface ogmp_cfg_if;
  import ogmp_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

[design/ogmp_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data
module ogmp_ram import ogmp_pkg::*; #(
  parameter int WIDTH = CELL_W,
  parameter int DEPTH = (DEF_MAX_WIDTH + 1) / 2
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [addr_width(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]             wdata,
  input  logic                         re,
  input  logic [addr_width(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[design/ogmp_front.sv]
// Front end: walks the raster position and tags each cell for the back end
module ogmp_front import ogmp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR,
  parameter type item_t    = logic
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  cfg_t                     cfg,
  input  logic                     restart,
  input  logic                     in_valid,
  input  logic signed [CELL_W-1:0] in_cell_value,
  output logic                     in_ready,
  input  logic                     q_full,
  output logic                     q_push,
  output item_t                    q_item
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = addr_width(LINE_DEPTH);
  localparam int CW         = addr_width(MAX_WIDTH);
  localparam int RW         = addr_width(MAX_HEIGHT);
  localparam int FW         = addr_width(MAX_FACTOR);
  localparam int WCMP_W     = max_int($clog2(MAX_WIDTH + 1), GRID_W);
  localparam int HCMP_W     = max_int($clog2(MAX_HEIGHT + 1), GRID_W);
  localparam int FCMP_W     = max_int($clog2(MAX_FACTOR + 1), FACTOR_W);

  logic [CW-1:0] col_r, col_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [FW-1:0] cib_r, cib_nxt;
  logic [FW-1:0] rib_r, rib_nxt;
  logic [AW-1:0] idx_r, idx_nxt;

  logic [FCMP_W-1:0] f_eff;
  logic [WCMP_W-1:0] w_eff;
  logic [HCMP_W-1:0] h_eff;
  logic              last_col, last_row, cib_wrap, rib_wrap;
  logic              single_col, pass;
  logic              accept;

  // Effective configuration after clamping
  always_comb begin
    if (cfg.pool_factor == '0) begin
      f_eff = FCMP_W'(1);
    end else if (FCMP_W'(cfg.pool_factor) > FCMP_W'(MAX_FACTOR)) begin
      f_eff = FCMP_W'(MAX_FACTOR);
    end else begin
      f_eff = FCMP_W'(cfg.pool_factor);
    end
    if (cfg.grid_width == '0) begin
      w_eff = WCMP_W'(1);
    end else if (WCMP_W'(cfg.grid_width) > WCMP_W'(MAX_WIDTH)) begin
      w_eff = WCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = WCMP_W'(cfg.grid_width);
    end
    if (cfg.grid_height == '0) begin
      h_eff = HCMP_W'(1);
    end else if (HCMP_W'(cfg.grid_height) > HCMP_W'(MAX_HEIGHT)) begin
      h_eff = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_eff = HCMP_W'(cfg.grid_height);
    end
  end

  assign last_col   = (WCMP_W'(col_r) + WCMP_W'(1)) >= w_eff;
  assign last_row   = (HCMP_W'(row_r) + HCMP_W'(1)) >= h_eff;
  assign cib_wrap   = (FCMP_W'(cib_r) + FCMP_W'(1)) >= f_eff;
  assign rib_wrap   = (FCMP_W'(rib_r) + FCMP_W'(1)) >= f_eff;
  // whole row fits in one block column: the previous cell always shares the entry
  assign single_col = w_eff <= WCMP_W'(f_eff);
  assign pass       = f_eff == FCMP_W'(1);

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept;

  always_comb begin
    q_item            = '0;
    q_item.cell_value = in_cell_value;
    q_item.idx        = idx_r;
    q_item.frame_end  = last_col && last_row;
    if (pass) begin
      q_item.src  = SRC_PASS;
      q_item.emit = 1'b1;
    end else begin
      if (cib_r == '0 && rib_r == '0) begin
        q_item.src = SRC_INIT;
      end else if (cib_r != '0 || single_col) begin
        q_item.src = SRC_PREV;
      end else begin
        q_item.src = SRC_MEM;
      end
      q_item.emit = (last_col || cib_wrap) && (last_row || rib_wrap);
    end
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cib_nxt = cib_r;
    rib_nxt = rib_r;
    idx_nxt = idx_r;
    if (restart) begin
      col_nxt = '0;
      row_nxt = '0;
      cib_nxt = '0;
      rib_nxt = '0;
      idx_nxt = '0;
    end else if (accept) begin
      if (last_col) begin
        col_nxt = '0;
        cib_nxt = '0;
        idx_nxt = '0;
        if (last_row) begin
          row_nxt = '0;
          rib_nxt = '0;
        end else begin
          row_nxt = row_r + RW'(1);
          rib_nxt = rib_wrap ? '0 : rib_r + FW'(1);
        end
      end else begin
        col_nxt = col_r + CW'(1);
        if (cib_wrap) begin
          cib_nxt = '0;
          idx_nxt = idx_r + AW'(1);
        end else begin
          cib_nxt = cib_r + FW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cib_r <= '0;
      rib_r <= '0;
      idx_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cib_r <= cib_nxt;
      rib_r <= rib_nxt;
      idx_r <= idx_nxt;
    end
  end

endmodule

[design/ogmp_queue.sv]
// Small register queue between the front end and the back end
module ogmp_queue import ogmp_pkg::*; #(
  parameter type item_t = logic,
  parameter int  DEPTH  = QUEUE_DEPTH
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  item_t push_item,
  output logic  full,
  input  logic  pop,
  output logic  valid,
  output item_t head
);

  localparam int PW = addr_width(DEPTH);
  localparam int NW = $clog2(DEPTH + 1);

  item_t         entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0] count_r, count_nxt;

  assign full  = count_r == NW'(DEPTH);
  assign valid = count_r != '0;
  assign head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + NW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - NW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

[design/ogmp_back.sv]
// Back end: line buffer read-modify-write, block maximum and result register
module ogmp_back import ogmp_pkg::*; #(
  parameter int  MAX_WIDTH = DEF_MAX_WIDTH,
  parameter type item_t    = logic
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  item_t                    q_head,
  output logic                     q_pop,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic signed [CELL_W-1:0] out_pooled_value,
  output logic                     out_frame_end
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  logic                     x_valid_r, x_valid_nxt;
  item_t                    x_item_r;
  logic signed [CELL_W-1:0] acc_r;
  logic                     out_valid_r, out_valid_nxt;
  logic signed [CELL_W-1:0] pooled_r;
  logic                     frame_end_r;

  logic                     out_free, x_fire, x_emit;
  logic signed [CELL_W-1:0] base, acc, result;
  logic [CELL_W-1:0]        ram_rdata;

  // The read issued with a dequeue lands with the item in the execute register.
  // A line entry read here was written at least two transactions earlier.
  ogmp_ram #(
    .WIDTH (CELL_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (x_fire && x_item_r.src != SRC_PASS),
    .waddr (x_item_r.idx),
    .wdata (acc),
    .re    (q_pop),
    .raddr (q_head.idx),
    .rdata (ram_rdata)
  );

  always_comb begin
    case (x_item_r.src)
      SRC_INIT: base = UNKNOWN_CELL;
      SRC_PREV: base = acc_r;
      SRC_MEM:  base = $signed(ram_rdata);
      default:  base = UNKNOWN_CELL;
    endcase
    acc    = (x_item_r.cell_value > base) ? x_item_r.cell_value : base;
    result = (x_item_r.src == SRC_PASS) ? x_item_r.cell_value : acc;
  end

  assign out_free = !out_valid_r || out_ready;
  assign x_emit   = x_valid_r && x_item_r.emit;
  assign x_fire   = x_valid_r && (!x_item_r.emit || out_free);
  assign q_pop    = q_valid && (!x_valid_r || x_fire);

  always_comb begin
    x_valid_nxt = x_valid_r;
    if (q_pop) begin
      x_valid_nxt = 1'b1;
    end else if (x_fire) begin
      x_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (x_fire && x_emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      x_item_r <= q_head;
    end
    if (x_fire) begin
      acc_r <= acc;
    end
    if (x_fire && x_emit) begin
      pooled_r    <= result;
      frame_end_r <= x_item_r.frame_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pooled_value = pooled_r;
  assign out_frame_end    = frame_end_r;

endmodule

[design/occupancy_grid_max_pool_unit.sv]
// Path: the last cell of a block passes the queue, the execute register and the result register.
// Throughput: one cell per cycle sustained while the output is not stalled; the line buffer
// does one read and one write per cycle, and the shallow queue absorbs output stalls until full.
// Reset: synchronous, active low; clears counters, queue and valid flags and loads
// pool_factor 2, grid_width 4096, grid_height 4096. The line buffer is not cleared and
// needs no clearing pass; a write to one of the three registers restarts the frame.
module occupancy_grid_max_pool_unit import ogmp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_FACTOR = DEF_MAX_FACTOR
) (
  input  logic       clk,
  input  logic       rst_n,
  ogmp_in_if.sink    in_ch,
  ogmp_out_if.source out_ch,
  ogmp_cfg_if.sink   cfg_ch
);

  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int AW         = addr_width(LINE_DEPTH);

  typedef struct packed {
    logic signed [CELL_W-1:0] cell_value;
    src_sel_t                 src;
    logic [AW-1:0]            idx;
    logic                     emit;
    logic                     frame_end;
  } q_item_t;

  cfg_t    cfg_r;
  logic    restart;
  logic    q_full, q_push, q_pop, q_valid;
  q_item_t q_in, q_head;

  assign cfg_ch.ready = 1'b1;
  assign restart = cfg_ch.valid && (cfg_ch.index == CFG_IDX_POOL_FACTOR ||
                                    cfg_ch.index == CFG_IDX_GRID_WIDTH ||
                                    cfg_ch.index == CFG_IDX_GRID_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pool_factor <= RST_POOL_FACTOR;
      cfg_r.grid_width  <= RST_GRID_WIDTH;
      cfg_r.grid_height <= RST_GRID_HEIGHT;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_IDX_POOL_FACTOR: cfg_r.pool_factor <= cfg_ch.data[FACTOR_W-1:0];
        CFG_IDX_GRID_WIDTH:  cfg_r.grid_width  <= cfg_ch.data[GRID_W-1:0];
        CFG_IDX_GRID_HEIGHT: cfg_r.grid_height <= cfg_ch.data[GRID_W-1:0];
        default: ;
      endcase
    end
  end

  ogmp_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_FACTOR (MAX_FACTOR),
    .item_t     (q_item_t)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .restart       (restart),
    .in_valid      (in_ch.valid),
    .in_cell_value (in_ch.cell_value),
    .in_ready      (in_ch.ready),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_in)
  );

  ogmp_queue #(
    .item_t (q_item_t),
    .DEPTH  (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  ogmp_back #(
    .MAX_WIDTH (MAX_WIDTH),
    .item_t    (q_item_t)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_pooled_value (out_ch.pooled_value),
    .out_frame_end    (out_ch.frame_end)
  );

endmodule

[design/ogmp_checker.sv]
// Port-level checks of the max pool unit and their bind to the top level
`include "assert_macros.svh"

module ogmp_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [7:0] out_pooled_value,
  input logic              out_frame_end
);

  // a pending result holds until its transaction completes
  `OGMP_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_pooled_value) && $stable(out_frame_end))

  // no result is valid after reset while the first cells fill the queue and execute register, whatever arrives
  `OGMP_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_valid ##1 !out_valid)

  // the queue is empty after reset, so cells are taken at once
  `OGMP_ASSERT_RST(a_reset_ready, clk, !rst_n |=> in_ready)

endmodule

bind occupancy_grid_max_pool_unit ogmp_checker u_ogmp_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ch.ready),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_pooled_value (out_ch.pooled_value),
  .out_frame_end    (out_ch.frame_end)
);
